/* rtl/ims_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ims_pkg
// Types shared by the integer membership set and its entry store.
// ----------------------------------------------------------------------------

package ims_pkg;

   localparam int unsigned FUNC_WIDTH  = 2;
   localparam int unsigned VALUE_WIDTH = 32;
   localparam int unsigned COUNT_OUT_WIDTH = 5;

   typedef enum logic [FUNC_WIDTH-1:0] {
      OP_INSERT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_FIND   = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   // update applied to the entry store in the cycle a request is retired
   typedef struct packed {
      logic                   clear_en;
      logic                   insert_en;
      logic                   erase_en;
      logic [VALUE_WIDTH-1:0] value;
   } update_type;

   // lookup status of the request being retired
   typedef struct packed {
      logic hit;
      logic room;
   } status_type;

endpackage

`default_nettype wire

/* rtl/ims_entries.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ims_entries
// Valid-flagged value entries with a parallel compare, lowest-free-slot
// insert, match erase and clear of all valid flags.
// ----------------------------------------------------------------------------

module ims_entries #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire ims_pkg::update_type upd,
   output ims_pkg::status_type      status
);

   logic [ims_pkg::VALUE_WIDTH-1:0] entry_value_ff [CAPACITY];
   logic [CAPACITY-1:0]             entry_valid_ff;
   logic [CAPACITY-1:0]             entry_valid_in;
   logic [CAPACITY-1:0]             match;
   logic [CAPACITY-1:0]             free_onehot;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = entry_valid_ff[i] && (entry_value_ff[i] == upd.value);
      end
   end

   // lowest clear bit of the valid vector
   assign free_onehot = ~entry_valid_ff & (entry_valid_ff + CAPACITY'(1));

   assign status.hit  = |match;
   assign status.room = |(~entry_valid_ff);

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (upd.clear_en) begin
         entry_valid_in = '0;
      end else if (upd.erase_en) begin
         entry_valid_in = entry_valid_ff & ~match;
      end else if (upd.insert_en) begin
         entry_valid_in = entry_valid_ff | free_onehot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         if (upd.insert_en && free_onehot[i]) begin
            entry_value_ff[i] <= upd.value;
         end
      end
   end

endmodule

`default_nettype wire

/* rtl/integer_membership_set.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// integer_membership_set
// Bounded set of signed 32-bit integers with insert, erase, find and clear.
// ----------------------------------------------------------------------------
// A request is registered on acceptance and retired once the response
// register is free or being drained: all CAPACITY entries are compared
// against the value at once, the entry store and member count are updated,
// and the result is loaded into the response register. One request is
// taken every cycle while responses are consumed. The response register
// lets a new request enter while the previous response still waits.
// Insert fills the lowest free entry; the member count output carries the
// low five bits of the count.
// ----------------------------------------------------------------------------

module integer_membership_set #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [1:0]  req_func,
   input  wire logic signed [31:0] req_item_value,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic        rsp_changed,
   output      logic        rsp_present,
   output      logic        rsp_full_refused,
   output      logic [4:0]  rsp_member_count
);

   localparam int unsigned CW = $clog2(CAPACITY + 1);

   logic                            in_valid_ff;
   ims_pkg::op_type                 op_ff;
   logic [ims_pkg::VALUE_WIDTH-1:0] value_ff;
   logic [CW-1:0]                   count_ff;
   logic [CW-1:0]                   count_in;

   logic                            rsp_valid_ff;
   logic                            changed_ff;
   logic                            present_ff;
   logic                            refused_ff;
   logic [CW-1:0]                   rsp_count_ff;

   logic                            advance;
   logic                            changed_in;
   logic                            present_in;
   logic                            refused_in;
   ims_pkg::update_type             upd;
   ims_pkg::status_type             status;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff    <= ims_pkg::op_type'(req_func);
         value_ff <= req_item_value;
      end
   end

   ims_entries #(
      .CAPACITY (CAPACITY)
   ) u_entries (
      .clock  (clock),
      .reset  (reset),
      .upd    (upd),
      .status (status)
   );

   always_comb begin
      upd.value     = value_ff;
      upd.clear_en  = 1'b0;
      upd.insert_en = 1'b0;
      upd.erase_en  = 1'b0;
      changed_in    = 1'b0;
      present_in    = 1'b0;
      refused_in    = 1'b0;
      count_in      = count_ff;
      unique case (op_ff)
         ims_pkg::OP_INSERT: begin
            present_in = status.hit;
            if (!status.hit) begin
               if (status.room) begin
                  upd.insert_en = advance;
                  changed_in    = 1'b1;
                  count_in      = count_ff + CW'(1);
               end else begin
                  refused_in = 1'b1;
               end
            end
         end
         ims_pkg::OP_ERASE: begin
            present_in = status.hit;
            if (status.hit) begin
               upd.erase_en = advance;
               changed_in   = 1'b1;
               count_in     = count_ff - CW'(1);
            end
         end
         ims_pkg::OP_FIND: begin
            present_in = status.hit;
         end
         ims_pkg::OP_CLEAR: begin
            upd.clear_en = advance;
            count_in     = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            count_ff <= count_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (advance) begin
         changed_ff   <= changed_in;
         present_ff   <= present_in;
         refused_ff   <= refused_in;
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_changed      = changed_ff;
   assign rsp_present      = present_ff;
   assign rsp_full_refused = refused_ff;
   assign rsp_member_count = ims_pkg::COUNT_OUT_WIDTH'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("member count above capacity");

   a_refused_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && refused_ff |-> count_ff == CW'(CAPACITY))
      else $error("insert refused while set had room");

   a_changed_not_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(changed_ff && refused_ff))
      else $error("response both changed and refused");

   a_stall_holds_count: assert property (@(posedge clock) disable iff (reset)
      !advance |=> count_ff == $past(count_ff))
      else $error("count moved without a retired request");

endmodule

`default_nettype wire

/* bench/integer_membership_set_tb.sv */
// ----------------------------------------------------------------------------
// integer_membership_set_tb
// Self-checking bench for the integer membership set.
// ----------------------------------------------------------------------------
// Requests are driven over the valid/ready request channel, and the expected
// response for each one is worked out from a shadow copy of the set when the
// request is accepted. A checker compares every response field against the
// oldest expected response. Both channels idle at random, and one phase holds
// the response side off long enough for the block to stall its input.
// ----------------------------------------------------------------------------

module integer_membership_set_tb;

   localparam int SET_CAPACITY   = 16;
   localparam int HOLD_CYCLES    = 50;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic       changed;
      logic       present;
      logic       full_refused;
      logic [4:0] member_count;
   } outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_func = 2'b00;
   logic [31:0] req_item_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_changed;
   logic        rsp_present;
   logic        rsp_full_refused;
   logic [4:0]  rsp_member_count;

   // shadow copy of the set
   logic [31:0] slot_value [SET_CAPACITY];
   bit          slot_used [SET_CAPACITY];
   int          used_count = 0;

   outcome_type pending_outcomes[$];
   logic [31:0] value_pool[$];
   int          error_count = 0;
   int          idle_cycles = 0;
   int          hold_requests = 0;
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;

   integer_membership_set #(
      .CAPACITY(SET_CAPACITY)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_item_value   (req_item_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_changed      (rsp_changed),
      .rsp_present      (rsp_present),
      .rsp_full_refused (rsp_full_refused),
      .rsp_member_count (rsp_member_count)
   );

   always #5 clock = ~clock;

   function automatic int gap_len();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 25);
   endfunction

   // updates the shadow set and queues the response the block must give
   function automatic void apply_set_request(input ims_pkg::op_type op,
                                             input logic [31:0] value);
      outcome_type res;
      int hit;
      int slot;
      res = '0;
      hit = -1;
      slot = -1;
      for (int i = 0; i < SET_CAPACITY; i++) begin
         if (hit < 0 && slot_used[i] && slot_value[i] == value) hit = i;
         if (slot < 0 && !slot_used[i]) slot = i;
      end
      case (op)
         ims_pkg::OP_INSERT: begin
            res.present = (hit >= 0);
            if (hit < 0) begin
               if (used_count >= SET_CAPACITY || slot < 0) begin
                  res.full_refused = 1'b1;
               end else begin
                  slot_value[slot] = value;
                  slot_used[slot] = 1'b1;
                  used_count++;
                  res.changed = 1'b1;
               end
            end
         end
         ims_pkg::OP_ERASE: begin
            res.present = (hit >= 0);
            if (hit >= 0) begin
               slot_used[hit] = 1'b0;
               used_count--;
               res.changed = 1'b1;
            end
         end
         ims_pkg::OP_FIND: begin
            res.present = (hit >= 0);
         end
         ims_pkg::OP_CLEAR: begin
            for (int i = 0; i < SET_CAPACITY; i++) slot_used[i] = 1'b0;
            used_count = 0;
         end
         default: ;
      endcase
      res.member_count = 5'(used_count);
      pending_outcomes.push_back(res);
   endfunction

   task automatic send_request(input ims_pkg::op_type op, input logic [31:0] value);
      int gap;
      if (req_idle_on) begin
         gap = gap_len();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_func <= op;
      req_item_value <= value;
      do @(posedge clock); while (!req_ready);
      apply_set_request(op, value);
   endtask

   task automatic drain_outcomes();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic ims_pkg::op_type pick_op();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return ims_pkg::OP_INSERT;
      if (roll < 70) return ims_pkg::OP_ERASE;
      if (roll < 98) return ims_pkg::OP_FIND;
      return ims_pkg::OP_CLEAR;
   endfunction

   function automatic logic [31:0] pick_value();
      if ($urandom_range(0, 9) == 0 || value_pool.size() == 0) return $urandom;
      return value_pool[$urandom_range(0, value_pool.size() - 1)];
   endfunction

   task automatic build_pool(input int entries);
      value_pool.delete();
      value_pool.push_back(32'h8000_0000);
      value_pool.push_back(32'h7FFF_FFFF);
      value_pool.push_back(32'h0000_0000);
      value_pool.push_back(32'hFFFF_FFFF);
      while (value_pool.size() < entries) value_pool.push_back($urandom);
   endtask

   task automatic test_basic_operations();
      send_request(ims_pkg::OP_FIND,   32'h0000_0000);
      send_request(ims_pkg::OP_CLEAR,  32'h0000_0000);
      send_request(ims_pkg::OP_ERASE,  32'h0000_0000);
      send_request(ims_pkg::OP_INSERT, 32'h0000_0000);
      send_request(ims_pkg::OP_INSERT, 32'h8000_0000);
      send_request(ims_pkg::OP_INSERT, 32'h7FFF_FFFF);
      send_request(ims_pkg::OP_INSERT, 32'hFFFF_FFFF);
      send_request(ims_pkg::OP_INSERT, 32'h0000_0001);
      send_request(ims_pkg::OP_INSERT, 32'h0000_0000);
      send_request(ims_pkg::OP_FIND,   32'h8000_0000);
      send_request(ims_pkg::OP_FIND,   32'h8000_0001);
      send_request(ims_pkg::OP_FIND,   32'h7FFF_FFFF);
      send_request(ims_pkg::OP_ERASE,  32'hFFFF_FFFF);
      send_request(ims_pkg::OP_ERASE,  32'hFFFF_FFFF);
      send_request(ims_pkg::OP_FIND,   32'hFFFF_FFFF);
      send_request(ims_pkg::OP_INSERT, 32'h5555_AAAA);
      send_request(ims_pkg::OP_ERASE,  32'h8000_0000);
      send_request(ims_pkg::OP_INSERT, 32'hAAAA_5555);
      send_request(ims_pkg::OP_CLEAR,  32'hFFFF_FFFF);
      send_request(ims_pkg::OP_FIND,   32'h0000_0000);
      send_request(ims_pkg::OP_ERASE,  32'h7FFF_FFFF);
      send_request(ims_pkg::OP_INSERT, 32'h7FFF_FFFF);
   endtask

   task automatic test_full_set();
      logic [31:0] members [SET_CAPACITY];
      send_request(ims_pkg::OP_CLEAR, $urandom);
      for (int i = 0; i < SET_CAPACITY; i++) begin
         members[i] = 32'hC000_0000 | (i << 8) | $urandom_range(0, 255);
         send_request(ims_pkg::OP_INSERT, members[i]);
      end
      send_request(ims_pkg::OP_INSERT, 32'h0000_0001);
      send_request(ims_pkg::OP_INSERT, members[3]);
      send_request(ims_pkg::OP_FIND, members[SET_CAPACITY - 1]);
      send_request(ims_pkg::OP_ERASE, members[7]);
      send_request(ims_pkg::OP_INSERT, 32'h0000_0001);
      send_request(ims_pkg::OP_INSERT, 32'h0000_0002);
      send_request(ims_pkg::OP_ERASE, 32'h0000_0002);
      send_request(ims_pkg::OP_CLEAR, 32'h0000_0000);
   endtask

   task automatic test_output_stall();
      req_idle_on = 1'b0;
      hold_requests++;
      build_pool(12);
      for (int i = 0; i < 30; i++) send_request(pick_op(), pick_value());
      req_idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int pool_sizes [7] = '{6, 20, 40, 12, 64, 24, 18};
      for (int round = 0; round < 7; round++) begin
         build_pool(pool_sizes[round]);
         req_idle_on = (round % 3 != 1);
         rsp_idle_on = (round % 3 != 2);
         for (int i = 0; i < 100; i++) send_request(pick_op(), pick_value());
      end
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   initial begin : response_side
      int gap;
      int holds_done;
      holds_done = 0;
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = hold_requests;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (rsp_idle_on) begin
            gap = gap_len();
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_response
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_changed !== want.changed) begin
               $error("changed mismatch: expected %0d, got %0d", want.changed, rsp_changed);
               error_count++;
            end
            if (rsp_present !== want.present) begin
               $error("present mismatch: expected %0d, got %0d", want.present, rsp_present);
               error_count++;
            end
            if (rsp_full_refused !== want.full_refused) begin
               $error("full_refused mismatch: expected %0d, got %0d",
                      want.full_refused, rsp_full_refused);
               error_count++;
            end
            if (rsp_member_count !== want.member_count) begin
               $error("member_count mismatch: expected %0d, got %0d",
                      want.member_count, rsp_member_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < SET_CAPACITY; i++) slot_used[i] = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_operations();
      test_full_set();
      test_output_stall();
      test_random_traffic();
      drain_outcomes();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ims_pkg.sv
rtl/ims_entries.sv
rtl/integer_membership_set.sv
bench/integer_membership_set_tb.sv
